// ----- sv/lhp_pkg.sv -----
// ----------------------------------------------------------------------------
// lhp_pkg
// Shared types, bin bounds and bin helpers for the latency histogram block.
// ----------------------------------------------------------------------------
package lhp_pkg;

	localparam int MAX_BINS  = 16;
	localparam int BIN_IDX_W = 4;
	localparam int DATA_W    = 32;
	localparam int PCT_NUM   = 95;
	localparam int PCT_DEN   = 100;
	localparam int TGT_W     = DATA_W + 7;
	localparam int ACC_W     = DATA_W + BIN_IDX_W + 7;

	localparam logic [DATA_W-1:0] ALL_ONES = '1;

	localparam logic [DATA_W-1:0] FINITE_BOUNDS [MAX_BINS-1] = '{
		32'd10, 32'd20, 32'd40, 32'd80, 32'd160, 32'd320, 32'd640, 32'd1000,
		32'd2000, 32'd5000, 32'd10000, 32'd20000, 32'd50000, 32'd100000,
		32'd200000
	};

	typedef struct packed {
		logic take;
		logic inc;
		logic scan;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic last;
	} sts_t;

	function automatic logic [DATA_W-1:0] bin_bound(logic [BIN_IDX_W-1:0] idx, int num_bins);
		logic [DATA_W-1:0] r;
		r = ALL_ONES;
		if ((int'(idx) < num_bins - 1) && (int'(idx) < MAX_BINS - 1))
			r = FINITE_BOUNDS[idx];
		return r;
	endfunction

	function automatic logic [BIN_IDX_W-1:0] bin_of(logic [DATA_W-1:0] v, int num_bins);
		logic [BIN_IDX_W-1:0] r;
		r = BIN_IDX_W'(num_bins - 1);
		for (int i = MAX_BINS - 1; i >= 0; i--) begin
			if ((i < num_bins) && (v <= bin_bound(BIN_IDX_W'(i), num_bins)))
				r = BIN_IDX_W'(i);
		end
		return r;
	endfunction

endpackage

// ----- sv/lhp_sample_if.sv -----
// ----------------------------------------------------------------------------
// lhp_sample_if
// Input channel: a latency sample or a clear command, valid/ready.
// ----------------------------------------------------------------------------
interface lhp_sample_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] delay_us;

	modport source(output valid, output kind, output delay_us, input ready);
	modport sink(input valid, input kind, input delay_us, output ready);
endinterface

// ----- sv/lhp_stats_if.sv -----
// ----------------------------------------------------------------------------
// lhp_stats_if
// Output channel: count, minimum, maximum and 95th percentile, valid/ready.
// ----------------------------------------------------------------------------
interface lhp_stats_if;
	logic        valid;
	logic        ready;
	logic [31:0] sample_count;
	logic [31:0] min_us;
	logic [31:0] max_us;
	logic [31:0] p95_us;

	modport source(output valid, output sample_count, output min_us, output max_us,
		output p95_us, input ready);
	modport sink(input valid, input sample_count, input min_us, input max_us,
		input p95_us, output ready);
endinterface

// ----- sv/lhp_ctrl.sv -----
// ----------------------------------------------------------------------------
// lhp_ctrl
// Sequencer: accept a word; for a sample, bump its bin and scan the bins; hand off the result.
// ----------------------------------------------------------------------------
module lhp_ctrl import lhp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_kind,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_INC, ST_SCAN, ST_OUT} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	assign cmd.take = in_valid && in_ready_q;
	assign cmd.inc  = (state_q == ST_INC);
	assign cmd.scan = (state_q == ST_SCAN);
	assign cmd.load = (state_q == ST_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						in_ready_q <= 1'b0;
						state_q    <= in_kind ? ST_OUT : ST_INC;
					end
				end
				ST_INC: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (sts.hit || sts.last)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						in_ready_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/lhp_dp.sv -----
// ----------------------------------------------------------------------------
// lhp_dp
// Datapath: running min/max/count, bin counters, cumulative percentile scan
// and the result register.
// ----------------------------------------------------------------------------
module lhp_dp import lhp_pkg::*; #(
	parameter int NUM_BINS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              kind,
	input  logic [DATA_W-1:0] delay_us,
	output logic [DATA_W-1:0] sample_count,
	output logic [DATA_W-1:0] min_us,
	output logic [DATA_W-1:0] max_us,
	output logic [DATA_W-1:0] p95_us
);

	localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

	logic [DATA_W-1:0] bins_q [NUM_BINS];
	logic [DATA_W-1:0] count_q;
	logic [DATA_W-1:0] min_q;
	logic [DATA_W-1:0] max_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TGT_W-1:0]  target_q;
	logic [ACC_W-1:0]  acc_q;
	logic [DATA_W-1:0] p95_q;
	logic [DATA_W-1:0] res_count_q;
	logic [DATA_W-1:0] res_min_q;
	logic [DATA_W-1:0] res_max_q;
	logic [DATA_W-1:0] res_p95_q;

	logic [DATA_W-1:0]    bin_rd;
	logic [ACC_W-1:0]     acc_n;
	logic [BIN_IDX_W-1:0] idx_ext;
	logic [BIN_IDX_W-1:0] lat_bin;

	assign bin_rd  = bins_q[idx_q];
	assign acc_n   = acc_q + ACC_W'(bin_rd) * ACC_W'(PCT_DEN);
	assign idx_ext = BIN_IDX_W'(idx_q);
	assign lat_bin = bin_of(delay_us, NUM_BINS);

	assign sts.hit  = (acc_n >= ACC_W'(target_q));
	assign sts.last = (idx_q == IDX_W'(NUM_BINS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++)
				bins_q[i] <= '0;
			count_q <= '0;
			min_q   <= ALL_ONES;
			max_q   <= '0;
		end else if (cmd.take) begin
			if (kind) begin
				for (int i = 0; i < NUM_BINS; i++)
					bins_q[i] <= '0;
				count_q <= '0;
				min_q   <= ALL_ONES;
				max_q   <= '0;
			end else begin
				count_q <= count_q + DATA_W'(1);
				if (delay_us < min_q)
					min_q <= delay_us;
				if (delay_us > max_q)
					max_q <= delay_us;
			end
		end else if (cmd.inc) begin
			bins_q[idx_q] <= bin_rd + DATA_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take)
			idx_q <= IDX_W'(lat_bin);
		if (cmd.inc) begin
			target_q <= TGT_W'(count_q) * TGT_W'(PCT_NUM);
			acc_q    <= '0;
			idx_q    <= '0;
		end
		if (cmd.scan) begin
			acc_q <= acc_n;
			if (sts.hit)
				p95_q <= bin_bound(idx_ext, NUM_BINS);
			else if (sts.last)
				p95_q <= max_q;
			else
				idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.load) begin
			res_count_q <= count_q;
			res_min_q   <= (count_q != '0) ? min_q : '0;
			res_max_q   <= max_q;
			res_p95_q   <= (count_q != '0) ? p95_q : '0;
		end
	end

	assign sample_count = res_count_q;
	assign min_us       = res_min_q;
	assign max_us       = res_max_q;
	assign p95_us       = res_p95_q;

endmodule

// ----- sv/latency_histogram_p95_top.sv -----
// ----------------------------------------------------------------------------
// latency_histogram_p95_top
// Log-binned latency histogram with running min/max/count and 95th percentile.
// ----------------------------------------------------------------------------
//  channel   dir  fields                                  handshake
//  samples   in   kind, delay_us                          valid/ready
//  stats     out  sample_count, min_us, max_us, p95_us    valid/ready
//
//  A sample word steps through accept, increment, a cumulative scan of
//  1..NUM_BINS bins and output; a clear word goes straight from accept to output.
//  The scan reads one bin counter per cycle.
//  One word is in flight at a time; the next is taken while a result waits.
//  A stalled result holds the block in its output state until taken.
//  Reset empties the histogram at once; the block is ready right after.
// ----------------------------------------------------------------------------
module latency_histogram_p95_top import lhp_pkg::*; #(
	parameter int NUM_BINS = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	lhp_sample_if.sink   samples,
	lhp_stats_if.source  stats
);

	cmd_t cmd;
	sts_t sts;

	lhp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_kind   (samples.kind),
		.in_ready  (samples.ready),
		.out_valid (stats.valid),
		.out_ready (stats.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lhp_dp #(
		.NUM_BINS (NUM_BINS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (samples.kind),
		.delay_us     (samples.delay_us),
		.sample_count (stats.sample_count),
		.min_us       (stats.min_us),
		.max_us       (stats.max_us),
		.p95_us       (stats.p95_us)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> !samples.ready)
		else $error("second word accepted while one is in flight");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(stats.valid && stats.sample_count != 32'd0) |-> (stats.min_us <= stats.max_us))
		else $error("reported minimum above maximum");

	a_min_le_p95: assert property (@(posedge clk) disable iff (!arst_n)
		(stats.valid && stats.sample_count != 32'd0) |-> (stats.min_us <= stats.p95_us))
		else $error("percentile bound below minimum");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.inc, cmd.scan, cmd.load}))
		else $error("overlapping datapath commands");

endmodule

// ----- test/latency_histogram_p95_top_tb.sv -----
// ----------------------------------------------------------------------------
// latency_histogram_p95_top_tb
// Feeds latency samples and clear commands into the histogram block with
// random idle gaps on both channels and one long output stall. Each result
// word is compared field by field with a local model of the bins, the
// running min/max, the sample count and the 95th percentile.
// ----------------------------------------------------------------------------
module latency_histogram_p95_top_tb;

	localparam int NUM_BINS     = 12;
	localparam int RANDOM_WORDS = 930;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 300;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	localparam logic [31:0] BIN_LIMITS [NUM_BINS-1] = '{
		32'd10, 32'd20, 32'd40, 32'd80, 32'd160, 32'd320, 32'd640, 32'd1000,
		32'd2000, 32'd5000, 32'd10000
	};

	typedef struct packed {
		logic        kind;
		logic [31:0] delay_us;
	} sample_word_t;

	typedef struct packed {
		logic [31:0] sample_count;
		logic [31:0] min_us;
		logic [31:0] max_us;
		logic [31:0] p95_us;
	} stats_word_t;

	logic clk;
	logic arst_n;

	lhp_sample_if samples_ch ();
	lhp_stats_if  stats_ch ();

	latency_histogram_p95_top #(
		.NUM_BINS(NUM_BINS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_ch),
		.stats  (stats_ch)
	);

	sample_word_t pending_words [$];
	stats_word_t  expected_stats [$];

	logic [31:0] bin_hits [NUM_BINS];
	logic [31:0] lat_min;
	logic [31:0] lat_max;
	logic [31:0] lat_count;

	int   total_words;
	int   words_in;
	int   errors;
	logic word_taken;
	int   gap_left;
	int   stall_left;
	int   drv_calm;
	int   rcv_calm;
	logic long_hold;
	int   skew_bin;

	always #5 clk = ~clk;

	function automatic logic [31:0] bin_limit(int idx);
		if (idx >= NUM_BINS - 1)
			return '1;
		return BIN_LIMITS[idx];
	endfunction

	function automatic int pick_pause(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic histogram_reset();
		for (int i = 0; i < NUM_BINS; i++)
			bin_hits[i] = '0;
		lat_min   = '1;
		lat_max   = '0;
		lat_count = '0;
	endtask

	task automatic record_word(input sample_word_t w, output stats_word_t s);
		int          b;
		logic [63:0] need;
		logic [63:0] acc;
		logic        found;
		if (w.kind == KIND_CLEAR) begin
			histogram_reset();
		end else begin
			if (w.delay_us < lat_min)
				lat_min = w.delay_us;
			if (w.delay_us > lat_max)
				lat_max = w.delay_us;
			lat_count = lat_count + 32'd1;
			b = NUM_BINS - 1;
			for (int i = NUM_BINS - 1; i >= 0; i--)
				if (w.delay_us <= bin_limit(i))
					b = i;
			bin_hits[b] = bin_hits[b] + 32'd1;
		end
		s.sample_count = lat_count;
		s.min_us       = (lat_count != 0) ? lat_min : '0;
		s.max_us       = lat_max;
		s.p95_us       = '0;
		if (lat_count != 0) begin
			need  = (64'(lat_count) * 64'd95 + 64'd99) / 64'd100;
			acc   = '0;
			found = 1'b0;
			s.p95_us = lat_max;
			for (int i = 0; i < NUM_BINS; i++) begin
				if (!found) begin
					acc = acc + 64'(bin_hits[i]);
					if (acc >= need) begin
						s.p95_us = bin_limit(i);
						found    = 1'b1;
					end
				end
			end
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		$display("MISMATCH %s: expected %0d (0x%08h), got %0d (0x%08h) at %0t",
			what, want, want, got, got, $realtime);
		errors++;
	endtask

	function automatic logic [31:0] make_latency();
		int b;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				b = $urandom_range(0, skew_bin);
				if (b == NUM_BINS - 1)
					return $urandom_range(32'hFFFFFFFF, 32'd10001);
				return $urandom_range(bin_limit(b), (b == 0) ? 32'd0 : bin_limit(b - 1) + 1);
			end
			6: begin
				b = $urandom_range(0, NUM_BINS - 2);
				return bin_limit(b) + 32'($urandom_range(0, 1));
			end
			7: return $urandom;
			8: return $urandom >> $urandom_range(0, 31);
			default: return $urandom_range(200000, 10001);
		endcase
	endfunction

	function automatic sample_word_t sample_of(logic [31:0] v);
		sample_word_t w;
		w.kind     = KIND_SAMPLE;
		w.delay_us = v;
		return w;
	endfunction

	function automatic sample_word_t clear_of(logic [31:0] v);
		sample_word_t w;
		w.kind     = KIND_CLEAR;
		w.delay_us = v;
		return w;
	endfunction

	// input acceptance first, then the result side
	always @(posedge clk) begin
		stats_word_t want;
		if (arst_n && samples_ch.valid && samples_ch.ready) begin
			record_word(sample_word_t'{samples_ch.kind, samples_ch.delay_us}, want);
			expected_stats.push_back(want);
			words_in++;
			word_taken <= 1'b1;
		end else begin
			word_taken <= 1'b0;
		end
		if (arst_n && stats_ch.valid && stats_ch.ready) begin
			if (expected_stats.size() == 0) begin
				report_mismatch("unexpected word, sample_count", '0,
					stats_ch.sample_count);
			end else begin
				want = expected_stats.pop_front();
				if (stats_ch.sample_count !== want.sample_count)
					report_mismatch("sample_count", want.sample_count, stats_ch.sample_count);
				if (stats_ch.min_us !== want.min_us)
					report_mismatch("min_us", want.min_us, stats_ch.min_us);
				if (stats_ch.max_us !== want.max_us)
					report_mismatch("max_us", want.max_us, stats_ch.max_us);
				if (stats_ch.p95_us !== want.p95_us)
					report_mismatch("p95_us", want.p95_us, stats_ch.p95_us);
			end
		end
	end

	always @(negedge clk) begin
		sample_word_t w;
		if (!arst_n) begin
			samples_ch.valid <= 1'b0;
		end else if (samples_ch.valid && !word_taken) begin
		end else if (gap_left > 0) begin
			samples_ch.valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_words.size() > 0) begin
			w = pending_words.pop_front();
			samples_ch.valid    <= 1'b1;
			samples_ch.kind     <= w.kind;
			samples_ch.delay_us <= w.delay_us;
			gap_left <= pick_pause(drv_calm);
		end else begin
			samples_ch.valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		int p;
		if (!arst_n) begin
			stats_ch.ready <= 1'b0;
		end else if (long_hold) begin
			stats_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stats_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			p = pick_pause(rcv_calm);
			stats_ch.ready <= (p == 0);
			if (p > 0)
				stall_left <= p - 1;
		end
	end

	// hold the result side off while the sender keeps offering words
	initial begin
		long_hold = 1'b0;
		wait (arst_n && words_in >= HOLD_AFTER);
		@(posedge clk);
		long_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold = 1'b0;
	end

	initial begin
		#5000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		samples_ch.valid    = 1'b0;
		samples_ch.kind     = KIND_SAMPLE;
		samples_ch.delay_us = '0;
		stats_ch.ready      = 1'b0;
		word_taken          = 1'b0;
		gap_left            = 0;
		stall_left          = 0;
		drv_calm            = 0;
		rcv_calm            = 0;
		words_in            = 0;
		errors              = 0;
		skew_bin            = NUM_BINS - 1;
		histogram_reset();

		pending_words.push_back(sample_of(32'd0));
		pending_words.push_back(sample_of(32'd10));
		pending_words.push_back(sample_of(32'd11));
		pending_words.push_back(sample_of(32'd20));
		pending_words.push_back(sample_of(32'd21));
		pending_words.push_back(sample_of(32'd40));
		pending_words.push_back(sample_of(32'd81));
		pending_words.push_back(sample_of(32'd160));
		pending_words.push_back(sample_of(32'd321));
		pending_words.push_back(sample_of(32'd640));
		pending_words.push_back(sample_of(32'd1000));
		pending_words.push_back(sample_of(32'd1001));
		pending_words.push_back(sample_of(32'd5000));
		pending_words.push_back(sample_of(32'd10000));
		pending_words.push_back(sample_of(32'd10001));
		pending_words.push_back(sample_of(32'hFFFFFFFF));
		pending_words.push_back(sample_of(32'h55555555));
		pending_words.push_back(sample_of(32'hAAAAAAAA));
		pending_words.push_back(clear_of(32'hFFFFFFFF));
		pending_words.push_back(clear_of(32'd0));
		pending_words.push_back(sample_of(32'hFFFFFFFF));
		pending_words.push_back(sample_of(32'd1));
		pending_words.push_back(clear_of(32'h12345678));

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if ($urandom_range(0, 59) == 0) begin
				pending_words.push_back(clear_of($urandom));
				skew_bin = $urandom_range(0, NUM_BINS - 1);
			end else begin
				pending_words.push_back(sample_of(make_latency()));
			end
		end
		total_words = pending_words.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (words_in == total_words);
		wait (expected_stats.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
